[rtl/core/mpsse_cmd_pkg.sv]
// mpsse_cmd_pkg: payload types, command codes, action codes and small lookup
// functions for the command decoder
// no dependencies
package mpsse_cmd_pkg;

  // one command-stream byte with the sampled pin levels
  typedef struct packed {
    logic [7:0] stream_byte;
    logic [3:0] pin_levels;
  } mpsse_in_t;

  // one decoded action
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic [3:0]  pin_dir;
    logic [2:0]  shift_kind;
    logic [19:0] count;
    logic [16:0] repeat_count;
    logic        capture_tdo;
    logic        tdi_level;
    logic [17:0] delay_value;
    logic        last;
  } mpsse_out_t;

  // action codes
  localparam logic [2:0] ACT_RESPOND  = 3'd0;
  localparam logic [2:0] ACT_FLUSH    = 3'd1;
  localparam logic [2:0] ACT_SET_PINS = 3'd2;
  localparam logic [2:0] ACT_SHIFT    = 3'd3;
  localparam logic [2:0] ACT_CLOCKS   = 3'd4;
  localparam logic [2:0] ACT_DELAY    = 3'd5;

  // shift kind that marks an undefined shift command
  localparam logic [2:0] KIND_INVALID = 3'd7;

  // command codes
  localparam logic [7:0] CMD_SET_LOW       = 8'h80;
  localparam logic [7:0] CMD_READ_LOW      = 8'h81;
  localparam logic [7:0] CMD_SET_HIGH      = 8'h82;
  localparam logic [7:0] CMD_READ_HIGH     = 8'h83;
  localparam logic [7:0] CMD_LOOP_ON       = 8'h84;
  localparam logic [7:0] CMD_LOOP_OFF      = 8'h85;
  localparam logic [7:0] CMD_SET_DIV       = 8'h86;
  localparam logic [7:0] CMD_FLUSH         = 8'h87;
  localparam logic [7:0] CMD_WAIT_HIGH     = 8'h88;
  localparam logic [7:0] CMD_WAIT_LOW      = 8'h89;
  localparam logic [7:0] CMD_DIV5_OFF      = 8'h8A;
  localparam logic [7:0] CMD_DIV5_ON       = 8'h8B;
  localparam logic [7:0] CMD_CLK_WAIT_HIGH = 8'h8C;
  localparam logic [7:0] CMD_CLK_WAIT_LOW  = 8'h8D;
  localparam logic [7:0] CMD_CLK_BITS      = 8'h8E;
  localparam logic [7:0] CMD_CLK_BYTES     = 8'h8F;
  localparam logic [7:0] CMD_ADAPT_ON      = 8'h96;
  localparam logic [7:0] CMD_ADAPT_OFF     = 8'h97;

  // response bytes
  localparam logic [7:0] PIN_READ_TAG = 8'hD0;
  localparam logic [7:0] BAD_CMD_TAG  = 8'hFA;
  localparam logic [7:0] ALL_ONES     = 8'hFF;

  // floor(n / 129) = (n * RECIP_129) >> RECIP_SHIFT, exact for n < 2**35
  localparam logic [27:0] RECIP_129   = 28'd266354561;
  localparam int unsigned RECIP_SHIFT = 35;

  // result queue depth in decoded items
  localparam int unsigned FIFO_DEPTH = 4;

  // shift kind from command bits 6, 3 and 0
  function automatic logic [2:0] shift_kind_of(input logic [7:0] cmd);
    logic [2:0] kind;
    if (cmd[6]) begin
      kind = cmd[3] ? {2'b10, cmd[0]} : KIND_INVALID;
    end else begin
      kind = {1'b0, cmd[3], cmd[0]};
    end
    return kind;
  endfunction

  // small divisors, 6 MHz base
  function automatic logic [4:0] delay_tab6(input logic [2:0] idx);
    logic [4:0] val;
    case (idx)
      3'd0:    val = 5'd1;
      3'd1:    val = 5'd5;
      3'd2:    val = 5'd8;
      3'd3:    val = 5'd12;
      3'd4:    val = 5'd16;
      3'd5:    val = 5'd20;
      default: val = 5'd1;
    endcase
    return val;
  endfunction

  // small divisors, 30 MHz base
  function automatic logic [4:0] delay_tab30(input logic [3:0] idx);
    logic [4:0] val;
    case (idx)
      4'd5:    val = 5'd2;
      4'd6:    val = 5'd3;
      4'd7:    val = 5'd4;
      4'd8:    val = 5'd4;
      4'd9:    val = 5'd5;
      4'd10:   val = 5'd6;
      4'd11:   val = 5'd7;
      4'd12:   val = 5'd8;
      4'd13:   val = 5'd8;
      4'd14:   val = 5'd8;
      4'd15:   val = 5'd9;
      default: val = 5'd1;
    endcase
    return val;
  endfunction

endpackage

[rtl/core/mpsse_command_decoder.sv]
// mpsse_command_decoder: top level, command parser, delay divider pipeline
// and result queue
// depends on mpsse_cmd_pkg
//
// usage
// - input channel (in_valid_i / in_ready_o / in_data_i) takes one command-stream
//   byte per transfer together with the sampled pin levels
// - output channel (out_valid_o / out_ready_i / out_data_o) gives the decoded
//   actions; a byte gives zero, one or two of them, last marks the final one
// - throughput: one byte per cycle while in_ready_o is high; every byte is
//   parsed in the cycle it is transferred and its actions pass two register
//   stages (the divisor reciprocal product is split over them) into the queue
// - a byte's first action is offered once it has passed both stages into the
//   queue; an unknown command's second action comes in the cycle after the first
// - the input stays ready while the queue plus the two stages hold fewer than
//   FIFO_DEPTH items, so a stalled receiver blocks input once they hold that
//   many, possibly before the queue itself fills; nothing is ever dropped
// - reset: parser idle, 6 MHz base selected, delay count one, queue empty
module mpsse_command_decoder
  import mpsse_cmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mpsse_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output mpsse_out_t out_data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  // parser phases
  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_LEN_L = 7'b0000010,
    PH_LEN_H = 7'b0000100,
    PH_XMIT  = 7'b0001000,
    PH_TMS   = 7'b0010000,
    PH_ARG0  = 7'b0100000,
    PH_ARG1  = 7'b1000000
  } phase_e;

  // action without delay and last; dual means bad-command tag first
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic [3:0]  pin_dir;
    logic [2:0]  shift_kind;
    logic [19:0] count;
    logic [16:0] repeat_count;
    logic        capture_tdo;
    logic        tdi_level;
    logic        dual;
  } act_t;

  // delay update work carried down the pipeline
  typedef struct packed {
    logic        upd;
    logic        hit;
    logic [4:0]  tab;
  } dly_t;

  typedef struct packed {
    act_t        act;
    logic [17:0] delay;
  } entry_t;

  // ---------------------------------------------------------------------------
  // parser state
  // ---------------------------------------------------------------------------
  phase_e      phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  arg_lo_q, arg_lo_d;
  logic        div5_q, div5_d;

  logic        in_fire;
  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] div_w;
  logic [16:0] div_p1;
  logic [2:0]  kind_cur;

  act_t        act_d;
  logic        act_vld_d;
  dly_t        dly_d;
  logic [24:0] num_d;

  assign in_fire  = in_valid_i & in_ready_o;
  assign b        = in_data_i.stream_byte;
  assign div_w    = {b, arg_lo_q};
  assign div_p1   = {1'b0, div_w} + 17'd1;
  assign kind_cur = shift_kind_of(cmd_q);
  assign len      = (phase_q == PH_LEN_H) ? {b, rem_q[7:0]} : {8'h00, b};

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    rem_d     = rem_q;
    arg_lo_d  = arg_lo_q;
    div5_d    = div5_q;
    act_d     = '0;
    act_vld_d = 1'b0;
    dly_d     = '0;
    num_d     = '0;

    if (in_fire) begin
      case (phase_q)
        PH_IDLE: begin
          cmd_d = b;
          if (b[7]) begin
            case (b)
              CMD_SET_LOW, CMD_SET_HIGH, CMD_SET_DIV, CMD_CLK_BITS,
              CMD_CLK_BYTES: begin
                phase_d = PH_ARG0;
              end
              CMD_READ_LOW: begin
                act_vld_d       = 1'b1;
                act_d.action    = ACT_RESPOND;
                act_d.data_byte = PIN_READ_TAG | {4'h0, in_data_i.pin_levels};
              end
              CMD_READ_HIGH: begin
                act_vld_d       = 1'b1;
                act_d.action    = ACT_RESPOND;
                act_d.data_byte = ALL_ONES;
              end
              CMD_FLUSH: begin
                act_vld_d    = 1'b1;
                act_d.action = ACT_FLUSH;
              end
              CMD_DIV5_OFF: begin
                div5_d = 1'b0;
              end
              CMD_DIV5_ON: begin
                div5_d = 1'b1;
              end
              CMD_LOOP_ON, CMD_LOOP_OFF, CMD_WAIT_HIGH, CMD_WAIT_LOW,
              CMD_CLK_WAIT_HIGH, CMD_CLK_WAIT_LOW, CMD_ADAPT_ON, CMD_ADAPT_OFF: begin
                phase_d = PH_IDLE;
              end
              default: begin
                act_vld_d       = 1'b1;
                act_d.action    = ACT_RESPOND;
                act_d.data_byte = b;
                act_d.dual      = 1'b1;
              end
            endcase
          end else if (shift_kind_of(b) == KIND_INVALID) begin
            act_vld_d       = 1'b1;
            act_d.action    = ACT_RESPOND;
            act_d.data_byte = b;
            act_d.dual      = 1'b1;
          end else begin
            phase_d = PH_LEN_L;
          end
        end

        PH_LEN_L, PH_LEN_H: begin
          rem_d = len;
          if ((phase_q == PH_LEN_L) && !cmd_q[1]) begin
            phase_d = PH_LEN_H;
          end else if (cmd_q[6]) begin
            phase_d = PH_TMS;
          end else if (cmd_q[4]) begin
            phase_d = PH_XMIT;
          end else begin
            // read-only shift, issued as soon as the length is known
            act_vld_d         = 1'b1;
            act_d.action      = ACT_SHIFT;
            act_d.data_byte   = ALL_ONES;
            act_d.shift_kind  = kind_cur;
            act_d.capture_tdo = cmd_q[5];
            if (cmd_q[1]) begin
              act_d.count        = {4'h0, len} + 20'd1;
              act_d.repeat_count = 17'd1;
            end else begin
              act_d.count        = 20'd8;
              act_d.repeat_count = {1'b0, len} + 17'd1;
            end
            rem_d   = '0;
            phase_d = PH_IDLE;
          end
        end

        PH_XMIT: begin
          act_vld_d          = 1'b1;
          act_d.action       = ACT_SHIFT;
          act_d.data_byte    = b;
          act_d.shift_kind   = kind_cur;
          act_d.capture_tdo  = cmd_q[5];
          act_d.repeat_count = 17'd1;
          if (cmd_q[1]) begin
            act_d.count = {4'h0, rem_q} + 20'd1;
            phase_d     = PH_IDLE;
          end else begin
            act_d.count = 20'd8;
            if (rem_q == '0) begin
              phase_d = PH_IDLE;
            end else begin
              rem_d = rem_q - 16'd1;
            end
          end
        end

        PH_TMS: begin
          act_vld_d          = 1'b1;
          act_d.action       = ACT_SHIFT;
          act_d.data_byte    = b;
          act_d.shift_kind   = kind_cur;
          act_d.capture_tdo  = cmd_q[5];
          act_d.count        = {4'h0, rem_q} + 20'd1;
          act_d.repeat_count = 17'd1;
          act_d.tdi_level    = b[7];
          phase_d            = PH_IDLE;
        end

        PH_ARG0: begin
          arg_lo_d = b;
          if (cmd_q == CMD_CLK_BITS) begin
            act_vld_d    = 1'b1;
            act_d.action = ACT_CLOCKS;
            act_d.count  = {12'h000, b} + 20'd1;
            phase_d      = PH_IDLE;
          end else begin
            phase_d = PH_ARG1;
          end
        end

        PH_ARG1: begin
          phase_d = PH_IDLE;
          case (cmd_q)
            CMD_SET_DIV: begin
              act_vld_d    = 1'b1;
              act_d.action = ACT_DELAY;
              dly_d.upd    = 1'b1;
              // both bases reduce to a division by 129
              if (div5_q) begin
                dly_d.hit = (div_w < 16'd6);
                dly_d.tab = delay_tab6(div_w[2:0]);
                num_d     = 25'({9'h000, div_w} * 25'd500) + 25'd145;
              end else begin
                dly_d.hit = (div_w < 16'd16);
                dly_d.tab = delay_tab30(div_w[3:0]);
                num_d     = 25'({9'h000, div_w} * 25'd100) - 25'd255;
              end
            end
            CMD_CLK_BYTES: begin
              act_vld_d    = 1'b1;
              act_d.action = ACT_CLOCKS;
              act_d.count  = {div_p1, 3'b000};
            end
            CMD_SET_LOW: begin
              act_vld_d       = 1'b1;
              act_d.action    = ACT_SET_PINS;
              act_d.data_byte = {4'h0, arg_lo_q[3:0]};
              act_d.pin_dir   = b[3:0];
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end

        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cmd_q    <= '0;
      rem_q    <= '0;
      arg_lo_q <= '0;
      div5_q   <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      rem_q    <= rem_d;
      arg_lo_q <= arg_lo_d;
      div5_q   <= div5_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: parsed action and divider numerator
  // stage 2: reciprocal partial products
  // ---------------------------------------------------------------------------
  logic        s1_vld_q, s2_vld_q;
  act_t        s1_act_q, s2_act_q;
  dly_t        s1_dly_q, s2_dly_q;
  logic [24:0] s1_num_q;
  logic [43:0] s2_plo_q;
  logic [36:0] s2_phi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= act_vld_d;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_act_q <= act_d;
    s1_dly_q <= dly_d;
    s1_num_q <= num_d;
    s2_act_q <= s1_act_q;
    s2_dly_q <= s1_dly_q;
    s2_plo_q <= {28'h0, s1_num_q[15:0]} * {16'h0, RECIP_129};
    s2_phi_q <= {28'h0, s1_num_q[24:16]} * {9'h0, RECIP_129};
  end

  // recombine partial products, keep the quotient
  logic [52:0] prod_sum;
  logic [17:0] quot;
  logic [17:0] delay_new;
  logic [17:0] delay_out;
  logic [17:0] delay_q;

  assign prod_sum  = {9'h000, s2_plo_q} + {s2_phi_q, 16'h0000};
  assign quot      = prod_sum[RECIP_SHIFT +: 18];
  assign delay_new = s2_dly_q.hit ? {13'h0000, s2_dly_q.tab} : quot;
  assign delay_out = s2_dly_q.upd ? delay_new : delay_q;

  // delay count in force, updated in stream order as items leave stage 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= 18'd1;
    end else if (s2_vld_q) begin
      delay_q <= delay_out;
    end
  end

  // ---------------------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------------------
  entry_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               sub_q;
  logic               push, pop, out_fire;
  logic [CNT_W:0]     inflight;
  entry_t             head;
  logic               first_of_two;

  assign head         = fifo_q[rd_q];
  assign first_of_two = head.act.dual & ~sub_q;
  assign push         = s2_vld_q;
  assign out_fire     = out_valid_o & out_ready_i;
  assign pop          = out_fire & ~first_of_two;

  // room for everything already in the pipe
  assign inflight   = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(s1_vld_q) + (CNT_W+1)'(s2_vld_q);
  assign in_ready_o = inflight < (CNT_W+1)'(FIFO_DEPTH);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{act: s2_act_q, delay: delay_out};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      sub_q <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
      // second transfer of an unknown command carries the command itself
      if (pop) begin
        sub_q <= 1'b0;
      end else if (out_fire) begin
        sub_q <= 1'b1;
      end
    end
  end

  assign out_valid_o              = (cnt_q != '0);
  assign out_data_o.action        = head.act.action;
  assign out_data_o.data_byte     = first_of_two ? BAD_CMD_TAG : head.act.data_byte;
  assign out_data_o.pin_dir       = head.act.pin_dir;
  assign out_data_o.shift_kind    = head.act.shift_kind;
  assign out_data_o.count         = head.act.count;
  assign out_data_o.repeat_count  = head.act.repeat_count;
  assign out_data_o.capture_tdo   = head.act.capture_tdo;
  assign out_data_o.tdi_level     = head.act.tdi_level;
  assign out_data_o.delay_value   = head.delay;
  assign out_data_o.last          = ~first_of_two;

endmodule

[rtl/core/mpsse_cmd_checker.sv]
// mpsse_cmd_checker: port-level checks for the command decoder, bound to the
// top level
// depends on mpsse_cmd_pkg and mpsse_command_decoder
module mpsse_cmd_checker
  import mpsse_cmd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input mpsse_in_t  in_data_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input mpsse_out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a non-final response is followed at once by the final one
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      out_valid_o && out_data_o.last && (out_data_o.action == ACT_RESPOND))
    else $error("second response of a pair missing");

  // shifts always move at least one bit, at least once
  a_shift_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.action == ACT_SHIFT) |->
      (out_data_o.count != '0) && (out_data_o.repeat_count != '0))
    else $error("shift with zero length");

  // delay count never drops to zero
  a_delay_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.delay_value != '0)
    else $error("zero delay count");

endmodule

bind mpsse_command_decoder mpsse_cmd_checker u_mpsse_cmd_checker (.*);
